// ----- src/dtfs_pkg.sv -----
// Package for the depth-tested frame store.
// Holds field widths, operation and register codes, transaction types and the FSM state type.
// Depends on nothing.
package dtfs_pkg;

  // Fixed field widths
  localparam int unsigned COLOUR_W  = 16;
  localparam int unsigned DEPTH_W   = 24;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // One stored word: red, green, blue, depth (depth in the low bits)
  localparam int unsigned WORD_W = 3 * COLOUR_W + DEPTH_W;

  // Depth value that stands for 1.0
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = {DEPTH_W{1'b1}};

  // Default store geometry
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  // Size register reset value
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [DEPTH_W-1:0]  depth;
    logic [COLOUR_W-1:0] clear_value;
  } dtfs_item_t;

  typedef struct packed {
    logic                accepted;
    logic                out_of_range;
    logic [COLOUR_W-1:0] read_red;
    logic [COLOUR_W-1:0] read_green;
    logic [COLOUR_W-1:0] read_blue;
    logic [DEPTH_W-1:0]  read_depth;
  } dtfs_result_t;

  // Memory port control between sequencer and store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } dtfs_mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CLEAR
  } dtfs_state_e;

endpackage

// ----- src/dtfs_ifs.sv -----
// Channel interfaces of the depth-tested frame store: item input, result output, configuration.
// Depends on dtfs_pkg.
interface dtfs_in_if import dtfs_pkg::*; ();
  logic       valid;
  logic       ready;
  dtfs_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtfs_out_if import dtfs_pkg::*; ();
  logic         valid;
  logic         ready;
  dtfs_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtfs_cfg_if import dtfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [SIZE_W-1:0]    wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ----- src/depth_tested_frame_store_top.sv -----
// Top level of the depth-tested frame store: size registers, sequencer and pixel store.
// Depends on dtfs_pkg, dtfs_ifs, dtfs_store, dtfs_ctrl.
//
//   channel   direction  payload                                          accepted when
//   in_ch     in         func, x, y, red, green, blue, depth, clear_value valid && ready
//   res_ch    out        accepted, out_of_range, read_*                   valid && ready
//   cfg_ch    in         idx (0 width, 1 height), wdata                   valid && ready
//
// A write or read: the store read issued on accept, then compare and write back on a free slot.
// A clear writes all MAX_WIDTH * MAX_HEIGHT store entries, one store entry written per cycle.
// One result per item, held in an output register; a result waits there while it is stalled.
// Reset clears control state and sets both sizes to 256; the store is not cleared by reset.
module depth_tested_frame_store_top import dtfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtfs_in_if.sink    in_ch,
  dtfs_out_if.source res_ch,
  dtfs_cfg_if.sink   cfg_ch
);

  localparam int unsigned ENTRIES = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  dtfs_mem_ctl_t     mem_ctl;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  // Size registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_WIDTH:  width_q  <= cfg_ch.wdata;
        CFG_HEIGHT: height_q <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  dtfs_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .res_ch    (res_ch),
    .width_i   (width_q),
    .height_i  (height_q),
    .mem_ctl_o (mem_ctl),
    .raddr_o   (raddr),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .rdata_i   (rdata)
  );

  dtfs_store #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

endmodule

// ----- src/dtfs_store.sv -----
// Pixel store: one synchronous single-port-write, single-port-read memory of colour and depth.
// Read data is registered. Depends on dtfs_pkg.
module dtfs_store import dtfs_pkg::*; #(
  parameter int unsigned ENTRIES = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int unsigned ADDR_W  = 16
) (
  input  logic                clk_i,
  input  dtfs_mem_ctl_t       ctl_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic [WORD_W-1:0]   wdata_i,
  output logic [WORD_W-1:0]   rdata_o
);

  logic [WORD_W-1:0] mem_q [ENTRIES];
  logic [WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dtfs_ctrl.sv -----
// Sequencer of the depth-tested frame store: takes items, runs the read-compare-write,
// sweeps the store on clear and holds the result register. Depends on dtfs_pkg, dtfs_ifs.
module dtfs_ctrl import dtfs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned ADDR_W     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dtfs_in_if.sink             in_ch,
  dtfs_out_if.source          res_ch,
  input  logic [SIZE_W-1:0]   width_i,
  input  logic [SIZE_W-1:0]   height_i,
  output dtfs_mem_ctl_t       mem_ctl_o,
  output logic [ADDR_W-1:0]   raddr_o,
  output logic [ADDR_W-1:0]   waddr_o,
  output logic [WORD_W-1:0]   wdata_o,
  input  logic [WORD_W-1:0]   rdata_i
);

  localparam int unsigned ENTRIES = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

  dtfs_state_e       state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  dtfs_item_t        item_q;
  logic [ADDR_W-1:0] addr_q;
  logic              inside_q;
  logic              res_valid_q;
  dtfs_result_t      res_q;
  dtfs_result_t      res_next;

  logic              in_ready;
  logic              in_fire;
  logic              slot_free;
  logic              res_load;
  logic              inside_in;
  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] addr_in;
  logic              write_pass;
  logic [DEPTH_W-1:0] stored_depth;

  assign in_fire   = in_ch.valid && in_ready;
  assign slot_free = !res_valid_q || res_ch.ready;

  // Position check and linear address of the incoming item
  assign inside_in = ({1'b0, in_ch.data.x} < width_i) && (32'(in_ch.data.x) < 32'(MAX_WIDTH))
                  && ({1'b0, in_ch.data.y} < height_i) && (32'(in_ch.data.y) < 32'(MAX_HEIGHT));
  assign addr_full = 32'(in_ch.data.y) * 32'(MAX_WIDTH) + 32'(in_ch.data.x);
  assign addr_in   = addr_full[ADDR_W-1:0];

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q   <= in_ch.data;
      addr_q   <= addr_in;
      inside_q <= inside_in;
    end
  end

  // Depth test against the stored word
  assign stored_depth = rdata_i[DEPTH_W-1:0];
  assign write_pass   = (item_q.func == FUNC_WRITE) && inside_q
                     && !(stored_depth < item_q.depth);

  // Result of the current item
  always_comb begin
    res_next = '0;
    unique case (item_q.func)
      FUNC_WRITE: begin
        res_next.out_of_range = !inside_q;
        res_next.accepted     = write_pass;
      end
      FUNC_READ: begin
        res_next.out_of_range = !inside_q;
        if (inside_q) begin
          res_next.read_red   = rdata_i[DEPTH_W+3*COLOUR_W-1 -: COLOUR_W];
          res_next.read_green = rdata_i[DEPTH_W+2*COLOUR_W-1 -: COLOUR_W];
          res_next.read_blue  = rdata_i[DEPTH_W+COLOUR_W-1 -: COLOUR_W];
          res_next.read_depth = stored_depth;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // State register and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state, memory control and handshake
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    mem_ctl_o = '0;
    waddr_o   = addr_q;
    wdata_o   = {item_q.red, item_q.green, item_q.blue, item_q.depth};
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          cnt_d = '0;
          if (in_ch.data.func == FUNC_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            state_d         = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (slot_free) begin
          res_load        = 1'b1;
          mem_ctl_o.wr_en = write_pass;
          state_d         = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        waddr_o         = cnt_q;
        wdata_o         = {item_q.clear_value, item_q.clear_value, item_q.clear_value, DEPTH_ONE};
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          state_d = ST_LOOK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign raddr_o     = addr_in;
  assign in_ch.ready = in_ready;

  // Result register: load on finish, drop on hand-over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_next;
    end
  end

  assign res_ch.valid = res_valid_q;
  assign res_ch.data  = res_q;

  // Checks
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_ctl_o.wr_en)
    else $error("store written while idle");

  a_read_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.rd_en |-> in_fire && state_d == ST_LOOK)
    else $error("store read without a taken transaction");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.accepted && res_q.out_of_range))
    else $error("write both stored and out of range");

  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && cnt_q != LAST_ADDR) |=> (state_q == ST_CLEAR
      && cnt_q == $past(cnt_q) + 1'b1))
    else $error("clear sweep skipped an entry");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> slot_free)
    else $error("result register overwritten");

endmodule
